// ===== src/bdqs_pkg.sv =====
package bdqs_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int VALUE_BITS_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int ITEM_W   = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int FVAL_W   = 32;
    localparam int FIDX_W   = 8;
    localparam int COUNT_W  = 9;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_SEARCH     = 3'd4,
        ACT_READ_POS   = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SEARCH,
        S_RESULT
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [FVAL_W-1:0]  found_value;
        logic [FIDX_W-1:0]  found_index;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } result_t;

endpackage

// ===== src/bdqs_ram.sv =====
module bdqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bdqs_ctrl.sv =====
module bdqs_ctrl #(
    parameter int CAPACITY   = bdqs_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = bdqs_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [bdqs_pkg::ACTION_W-1:0]       action,
    input  logic signed [bdqs_pkg::ITEM_W-1:0]  item_value,
    input  logic [bdqs_pkg::POS_W-1:0]          position,
    output logic                                res_valid,
    input  logic                                res_ready,
    output bdqs_pkg::result_t                   res,
    output logic                                ram_we,
    output logic [$clog2(CAPACITY)-1:0]         ram_waddr,
    output logic [VALUE_BITS-1:0]               ram_wdata,
    output logic [$clog2(CAPACITY)-1:0]         ram_raddr,
    input  logic [VALUE_BITS-1:0]               ram_rdata
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int CMP_W = (CNT_W > bdqs_pkg::POS_W) ? CNT_W : bdqs_pkg::POS_W;
    localparam int EXT_W = (CNT_W > bdqs_pkg::COUNT_W) ? CNT_W : bdqs_pkg::COUNT_W;

    bdqs_pkg::state_t             state_reg, state_next;
    logic [bdqs_pkg::ACTION_W-1:0] act_reg, act_next;
    logic [VALUE_BITS-1:0]         val_reg, val_next;
    logic [bdqs_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [PTR_W-1:0]              front_reg, front_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              issue_reg, issue_next;
    logic [CNT_W-1:0]              cmp_idx_reg, cmp_idx_next;
    logic                          pend_reg, pend_next;
    bdqs_pkg::status_t             status_reg, status_next;
    logic [bdqs_pkg::FVAL_W-1:0]   fval_reg, fval_next;
    logic [CNT_W-1:0]              fidx_reg, fidx_next;

    logic                          is_full;
    logic                          is_empty;
    logic [PTR_W-1:0]              front_dec;
    logic [CMP_W-1:0]              pos_ext;
    logic [CMP_W-1:0]              cnt_cmp;
    logic [EXT_W-1:0]              cnt_ext;
    logic [EXT_W-1:0]              fidx_ext;

    // front + off, wrapped into the ring
    function automatic logic [PTR_W-1:0] ring(input logic [PTR_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY))
        begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? PTR_W'(CAPACITY - 1) : front_reg - 1'b1;
    assign pos_ext   = CMP_W'(pos_reg);
    assign cnt_cmp   = CMP_W'(count_reg);
    assign cnt_ext   = EXT_W'(count_reg);
    assign fidx_ext  = EXT_W'(fidx_reg);

    assign res.status      = status_reg;
    assign res.found_value = fval_reg;
    assign res.found_index = fidx_ext[bdqs_pkg::FIDX_W-1:0];
    assign res.entry_count = cnt_ext[bdqs_pkg::COUNT_W-1:0];
    assign res.is_empty    = is_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdqs_pkg::S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
        fval_reg    <= fval_next;
        fidx_reg    <= fidx_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        issue_next   = issue_reg;
        cmp_idx_next = cmp_idx_reg;
        pend_next    = pend_reg;
        status_next  = status_reg;
        fval_next    = fval_reg;
        fidx_next    = fidx_reg;
        req_ready    = 1'b0;
        res_valid    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = front_reg;
        ram_wdata    = val_reg;
        ram_raddr    = ring(front_reg, issue_reg);

        case (state_reg)
            bdqs_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    act_next   = action;
                    val_next   = VALUE_BITS'(item_value);
                    pos_next   = position;
                    state_next = bdqs_pkg::S_EXEC;
                end
            end

            bdqs_pkg::S_EXEC:
            begin
                status_next = bdqs_pkg::STAT_OK;
                fval_next   = '0;
                fidx_next   = '0;
                issue_next  = '0;
                pend_next   = 1'b0;
                state_next  = bdqs_pkg::S_RESULT;
                case (act_reg)
                    bdqs_pkg::ACT_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = bdqs_pkg::STAT_FULL;
                        end
                        else
                        begin
                            front_next = front_dec;
                            ram_we     = 1'b1;
                            ram_waddr  = front_dec;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bdqs_pkg::ACT_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = bdqs_pkg::STAT_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = ring(front_reg, count_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bdqs_pkg::ACT_POP_FRONT:
                    begin
                        if (is_empty)
                        begin
                            status_next = bdqs_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            front_next = ring(front_reg, CNT_W'(1));
                            count_next = count_reg - 1'b1;
                        end
                    end
                    bdqs_pkg::ACT_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = bdqs_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    bdqs_pkg::ACT_SEARCH:
                    begin
                        if (is_empty)
                        begin
                            status_next = bdqs_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            state_next = bdqs_pkg::S_SEARCH;
                        end
                    end
                    bdqs_pkg::ACT_READ_POS:
                    begin
                        if (is_empty)
                        begin
                            status_next = bdqs_pkg::STAT_EMPTY;
                        end
                        else if (pos_ext >= cnt_cmp)
                        begin
                            status_next = bdqs_pkg::STAT_NOTFOUND;
                        end
                        else
                        begin
                            ram_raddr  = ring(front_reg, pos_ext[CNT_W-1:0]);
                            state_next = bdqs_pkg::S_RDWAIT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            bdqs_pkg::S_RDWAIT:
            begin
                fval_next  = bdqs_pkg::FVAL_W'($signed(ram_rdata));
                state_next = bdqs_pkg::S_RESULT;
            end

            // one read issued and one compare done per cycle
            bdqs_pkg::S_SEARCH:
            begin
                if (pend_reg && (ram_rdata == val_reg))
                begin
                    status_next = bdqs_pkg::STAT_OK;
                    fval_next   = bdqs_pkg::FVAL_W'($signed(ram_rdata));
                    fidx_next   = cmp_idx_reg;
                    pend_next   = 1'b0;
                    state_next  = bdqs_pkg::S_RESULT;
                end
                else if (pend_reg && (cmp_idx_reg == count_reg - 1'b1))
                begin
                    status_next = bdqs_pkg::STAT_NOTFOUND;
                    pend_next   = 1'b0;
                    state_next  = bdqs_pkg::S_RESULT;
                end
                else
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = issue_reg;
                    issue_next   = issue_reg + 1'b1;
                end
            end

            bdqs_pkg::S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = bdqs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bdqs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bounded_deque_with_search_top.sv =====
// Bounded double-ended queue of CAPACITY signed entries in a ring RAM, with
// push/pop at both ends, a first-match search and a read by position from the
// front. One request is taken at a time and gives one result transfer.
// Each request is registered in S_IDLE, executed in S_EXEC and offered in
// S_RESULT; a position read passes S_RDWAIT, and a search loops in S_SEARCH:
// the single RAM read port delivers one entry per cycle to the comparator,
// which walks from the front and stops at the first match. A registered output
// stage lets the next request be accepted while a result waits to be taken.
module bounded_deque_with_search_top #(
    parameter int CAPACITY   = bdqs_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = bdqs_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // item_value[31:0], position[39:32]
    input  logic [bdqs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action[2:0]
    input  logic [bdqs_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // found_value[31:0], found_index[39:32], entry_count[48:40], is_empty[49]
    output logic [bdqs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status[1:0]
    output logic [bdqs_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int PAD_W = bdqs_pkg::OUT_TDATA_W - bdqs_pkg::FVAL_W - bdqs_pkg::FIDX_W
                           - bdqs_pkg::COUNT_W - 1;

    logic                    res_valid;
    logic                    res_ready;
    bdqs_pkg::result_t       res;
    logic                    ram_we;
    logic [PTR_W-1:0]        ram_waddr;
    logic [VALUE_BITS-1:0]   ram_wdata;
    logic [PTR_W-1:0]        ram_raddr;
    logic [VALUE_BITS-1:0]   ram_rdata;

    logic                    out_valid_reg, out_valid_next;
    bdqs_pkg::result_t       out_reg, out_next;

    bdqs_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_axis_tvalid),
        .req_ready  (s_axis_tready),
        .action     (s_axis_tuser[bdqs_pkg::ACTION_W-1:0]),
        .item_value ($signed(s_axis_tdata[bdqs_pkg::ITEM_W-1:0])),
        .position   (s_axis_tdata[bdqs_pkg::ITEM_W +: bdqs_pkg::POS_W]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    bdqs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_reg.is_empty, out_reg.entry_count,
                            out_reg.found_index, out_reg.found_value};

endmodule
